>>> rtl/tbo_pkg.sv
// ----------------------------------------------------------------------------
// tbo_pkg
// Shared constants for the triangle / box overlap pipeline: default
// coordinate width, configuration register indexes and the edge-axis table.
// ----------------------------------------------------------------------------
package tbo_pkg;

	// default coordinate width (Q16.16 words)
	localparam int CoordBitsDefault = 32;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_CTR_X  = 3'd0,
		REG_CTR_Y  = 3'd1,
		REG_CTR_Z  = 3'd2,
		REG_EXT_X  = 3'd3,
		REG_EXT_Y  = 3'd4,
		REG_EXT_Z  = 3'd5,
		REG_FULL   = 3'd6,
		REG_UNUSED = 3'd7
	} cfg_reg_t;

	// edge cross-axis tests, one per triangle edge and box axis: edge, two axis components, two vertices
	localparam int AxEdge [9] = '{0, 0, 0, 1, 1, 1, 2, 2, 2};
	localparam int AxIa   [9] = '{1, 2, 0, 1, 2, 0, 1, 2, 0};
	localparam int AxIb   [9] = '{2, 0, 1, 2, 0, 1, 2, 0, 1};
	localparam int AxVp   [9] = '{0, 0, 1, 0, 0, 0, 0, 0, 1};
	localparam int AxVq   [9] = '{2, 2, 2, 2, 2, 1, 1, 1, 2};

endpackage

>>> rtl/tbo_axis.sv
// ----------------------------------------------------------------------------
// tbo_axis
// One edge cross-axis separation test, three stages: products, sums, compare.
// ----------------------------------------------------------------------------
module tbo_axis import tbo_pkg::*; #(
	parameter int COORD_BITS = CoordBitsDefault
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic signed [COORD_BITS+1:0] ea,
	input  logic signed [COORD_BITS+1:0] eb,
	input  logic signed [COORD_BITS:0]   vpa,
	input  logic signed [COORD_BITS:0]   vpb,
	input  logic signed [COORD_BITS:0]   vqa,
	input  logic signed [COORD_BITS:0]   vqb,
	input  logic        [COORD_BITS-2:0] xa,
	input  logic        [COORD_BITS-2:0] xb,
	output logic                         sep_s5
);

	localparam int EW = COORD_BITS + 2;
	localparam int AW = 2 * COORD_BITS + 5;

	logic signed [EW:0]   abs_a, abs_b;
	logic signed [AW-1:0] m0_s3, m1_s3, m2_s3, m3_s3, r0_s3, r1_s3;
	logic signed [AW-1:0] p0_s4, p1_s4, rad_s4, nrad;

	// magnitudes of the edge components
	assign abs_a = ea[EW-1] ? -((EW+1)'(ea)) : (EW+1)'(ea);
	assign abs_b = eb[EW-1] ? -((EW+1)'(eb)) : (EW+1)'(eb);

	// products
	always_ff @(posedge clk) begin
		if (en) begin
			m0_s3 <= AW'(eb) * AW'(vpa);
			m1_s3 <= AW'(ea) * AW'(vpb);
			m2_s3 <= AW'(eb) * AW'(vqa);
			m3_s3 <= AW'(ea) * AW'(vqb);
			r0_s3 <= AW'(abs_b) * AW'($signed({1'b0, xa}));
			r1_s3 <= AW'(abs_a) * AW'($signed({1'b0, xb}));
		end
	end

	// projections and radius
	always_ff @(posedge clk) begin
		if (en) begin
			p0_s4  <= m0_s3 - m1_s3;
			p1_s4  <= m2_s3 - m3_s3;
			rad_s4 <= r0_s3 + r1_s3;
		end
	end

	assign nrad = -rad_s4;

	// separated when both projections lie beyond the same side
	always_ff @(posedge clk) begin
		if (en) begin
			sep_s5 <= (p0_s4 > rad_s4 && p1_s4 > rad_s4) ||
				(p0_s4 < nrad && p1_s4 < nrad);
		end
	end

endmodule

>>> rtl/tbo_plane.sv
// ----------------------------------------------------------------------------
// tbo_plane
// Triangle plane test: normal, projection of the box radius and of a vertex,
// then compare. Six stages from the edge inputs to the reject flag; the wide
// projection products are split into a low and a high half of the normal.
// ----------------------------------------------------------------------------
module tbo_plane import tbo_pkg::*; #(
	parameter int COORD_BITS = CoordBitsDefault
) (
	input  logic                         clk,
	input  logic                         en,
	input  logic signed [COORD_BITS+1:0] e0 [3],
	input  logic signed [COORD_BITS+1:0] e1 [3],
	input  logic signed [COORD_BITS:0]   v0 [3],
	input  logic        [COORD_BITS-2:0] ext [3],
	output logic                         rej_s8
);

	localparam int NW = 2 * COORD_BITS + 5;
	localparam int DW = 3 * COORD_BITS + 9;
	// normal split: low slice unsigned, high slice signed
	localparam int LW = (NW + 1) / 2;
	localparam int HW = NW - LW;
	localparam int PL = LW + COORD_BITS + 2;
	localparam int PH = HW + COORD_BITS + 1;

	logic signed [NW-1:0]       pa_s3 [3];
	logic signed [NW-1:0]       pb_s3 [3];
	logic signed [COORD_BITS:0] v0_s3 [3];
	logic signed [NW-1:0]       n_s4 [3];
	logic        [NW-1:0]       a_s4 [3];
	logic signed [COORD_BITS:0] v0_s4 [3];
	logic signed [PL-1:0]       nl_s5 [3];
	logic signed [PH-1:0]       nh_s5 [3];
	logic signed [PL-1:0]       al_s5 [3];
	logic signed [PH-1:0]       ah_s5 [3];
	logic signed [DW-1:0]       nv_s6 [3];
	logic signed [DW-1:0]       an_s6 [3];
	logic signed [DW-1:0]       d_s7, r_s7;

	// cross product terms
	always_ff @(posedge clk) begin
		if (en) begin
			for (int q = 0; q < 3; q++) begin
				pa_s3[q] <= NW'(e0[(q+1)%3]) * NW'(e1[(q+2)%3]);
				pb_s3[q] <= NW'(e0[(q+2)%3]) * NW'(e1[(q+1)%3]);
				v0_s3[q] <= v0[q];
			end
		end
	end

	// normal and its magnitude
	always_ff @(posedge clk) begin
		if (en) begin
			for (int q = 0; q < 3; q++) begin
				n_s4[q]  <= pa_s3[q] - pb_s3[q];
				a_s4[q]  <= (pa_s3[q] < pb_s3[q]) ? pb_s3[q] - pa_s3[q] :
					pa_s3[q] - pb_s3[q];
				v0_s4[q] <= v0_s3[q];
			end
		end
	end

	// half products of n.v0 and |n|.ext
	always_ff @(posedge clk) begin
		if (en) begin
			for (int q = 0; q < 3; q++) begin
				nl_s5[q] <= PL'($signed({1'b0, n_s4[q][LW-1:0]})) * PL'(v0_s4[q]);
				nh_s5[q] <= PH'($signed(n_s4[q][NW-1:LW])) * PH'(v0_s4[q]);
				al_s5[q] <= PL'($signed({1'b0, a_s4[q][LW-1:0]})) *
					PL'($signed({1'b0, ext[q]}));
				ah_s5[q] <= PH'($signed({1'b0, a_s4[q][NW-1:LW]})) *
					PH'($signed({1'b0, ext[q]}));
			end
		end
	end

	// recombine the halves
	always_ff @(posedge clk) begin
		if (en) begin
			for (int q = 0; q < 3; q++) begin
				nv_s6[q] <= (DW'(nh_s5[q]) <<< LW) + DW'(nl_s5[q]);
				an_s6[q] <= (DW'(ah_s5[q]) <<< LW) + DW'(al_s5[q]);
			end
		end
	end

	// plane offset and box radius along the normal
	always_ff @(posedge clk) begin
		if (en) begin
			d_s7 <= nv_s6[0] + nv_s6[1] + nv_s6[2];
			r_s7 <= an_s6[0] + an_s6[1] + an_s6[2];
		end
	end

	// plane misses the box
	always_ff @(posedge clk) begin
		if (en) begin
			rej_s8 <= (d_s7 > r_s7) || (d_s7 < -r_s7);
		end
	end

endmodule

>>> rtl/triangle_box_overlap_test.sv
// ----------------------------------------------------------------------------
// triangle_box_overlap_test
// Separating-axis overlap test of one triangle against a configured box.
// ----------------------------------------------------------------------------
// An eight-stage pipeline that takes one triangle word per clock while the
// output is not stalled and returns one result word per triangle; the result
// is offered on m_axis_tvalid by the last stage, stage 8, of the pipeline. The
// stage count is set by the plane test: after the vertex shift and the edge
// stage come the normal products, the normal, the projection products (split
// into two halves of the normal), their recombination, the sum over the three
// axes and the final compare. The whole pipeline holds while a finished
// result waits for m_axis_tready; input words are taken whenever the last
// stage is empty or is being drained. Configuration writes are always
// accepted and must be made while no triangle is in flight.
// ----------------------------------------------------------------------------
module triangle_box_overlap_test import tbo_pkg::*; #(
	parameter int COORD_BITS = CoordBitsDefault,
	localparam int IN_W  = ((9 * COORD_BITS + 32 + 7) / 8) * 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [2:0]            cfg_index,
	input  logic [COORD_BITS-1:0] cfg_data,
	// triangle words
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// vertex0_x/y/z, vertex1_x/y/z, vertex2_x/y/z, triangle_tag, zero pad
	input  logic [IN_W-1:0]       s_axis_tdata,
	// result words
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// overlaps, result_tag, zero pad
	output logic [39:0]           m_axis_tdata
);

	localparam int CW = COORD_BITS;
	localparam int VW = CW + 1;
	localparam int EW = CW + 2;

	logic signed [CW-1:0] ctr_q [3];
	logic        [CW-2:0] ext_q [3];
	logic                 full_q;
	logic                 en;

	logic                 v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	logic [31:0]          tag_s1, tag_s2, tag_s3, tag_s4, tag_s5, tag_s6, tag_s7, tag_s8;
	logic signed [VW-1:0] vtx_s1 [3][3];
	logic signed [VW-1:0] vtx_s2 [3][3];
	logic signed [EW-1:0] edg_s2 [3][3];
	logic                 face_s2, face_s3, face_s4, face_s5, face_s6, face_s7, face_s8;
	logic [8:0]           sep_s5;
	logic                 axis_s6, axis_s7, axis_s8;
	logic                 plane_s8;
	logic [2:0]           face_lo, face_hi;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int q = 0; q < 3; q++) begin
				ctr_q[q] <= '0;
				ext_q[q] <= '0;
			end
			full_q <= 1'b1;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_CTR_X: ctr_q[0] <= cfg_data;
				REG_CTR_Y: ctr_q[1] <= cfg_data;
				REG_CTR_Z: ctr_q[2] <= cfg_data;
				REG_EXT_X: ext_q[0] <= cfg_data[CW-2:0];
				REG_EXT_Y: ext_q[1] <= cfg_data[CW-2:0];
				REG_EXT_Z: ext_q[2] <= cfg_data[CW-2:0];
				REG_FULL:  full_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// global advance: the pipeline moves unless a result is stuck at the end
	assign en            = !v_s8 || m_axis_tready;
	assign s_axis_tready = en;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8} <= '0;
		end else if (en) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8} <=
				{s_axis_tvalid, v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7};
		end
	end

	// stage 1: move vertices to box-centred coordinates
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				for (int q = 0; q < 3; q++) begin
					vtx_s1[k][q] <= VW'($signed(s_axis_tdata[(3*k+q)*CW +: CW])) -
						VW'(ctr_q[q]);
				end
			end
			tag_s1 <= s_axis_tdata[9*CW +: 32];
		end
	end

	// face axis reject terms
	always_comb begin
		for (int q = 0; q < 3; q++) begin
			face_lo[q] = vtx_s1[0][q] > $signed({1'b0, ext_q[q]}) &&
				vtx_s1[1][q] > $signed({1'b0, ext_q[q]}) &&
				vtx_s1[2][q] > $signed({1'b0, ext_q[q]});
			face_hi[q] = vtx_s1[0][q] < -$signed({2'b0, ext_q[q]}) &&
				vtx_s1[1][q] < -$signed({2'b0, ext_q[q]}) &&
				vtx_s1[2][q] < -$signed({2'b0, ext_q[q]});
		end
	end

	// stage 2: edges and face test
	always_ff @(posedge clk) begin
		if (en) begin
			for (int q = 0; q < 3; q++) begin
				edg_s2[0][q] <= EW'(vtx_s1[1][q]) - EW'(vtx_s1[0][q]);
				edg_s2[1][q] <= EW'(vtx_s1[2][q]) - EW'(vtx_s1[1][q]);
				edg_s2[2][q] <= EW'(vtx_s1[0][q]) - EW'(vtx_s1[2][q]);
				for (int k = 0; k < 3; k++) begin
					vtx_s2[k][q] <= vtx_s1[k][q];
				end
			end
			face_s2 <= |(face_lo | face_hi);
			tag_s2  <= tag_s1;
		end
	end

	// plane test
	tbo_plane #(
		.COORD_BITS (COORD_BITS)
	) u_plane (
		.clk    (clk),
		.en     (en),
		.e0     (edg_s2[0]),
		.e1     (edg_s2[1]),
		.v0     (vtx_s2[0]),
		.ext    (ext_q),
		.rej_s8 (plane_s8)
	);

	// edge cross-axis tests
	for (genvar a = 0; a < 9; a++) begin : g_axis
		tbo_axis #(
			.COORD_BITS (COORD_BITS)
		) u_axis (
			.clk    (clk),
			.en     (en),
			.ea     (edg_s2[AxEdge[a]][AxIa[a]]),
			.eb     (edg_s2[AxEdge[a]][AxIb[a]]),
			.vpa    (vtx_s2[AxVp[a]][AxIa[a]]),
			.vpb    (vtx_s2[AxVp[a]][AxIb[a]]),
			.vqa    (vtx_s2[AxVq[a]][AxIa[a]]),
			.vqb    (vtx_s2[AxVq[a]][AxIb[a]]),
			.xa     (ext_q[AxIa[a]]),
			.xb     (ext_q[AxIb[a]]),
			.sep_s5 (sep_s5[a])
		);
	end

	// stages 3 to 8: carry tag and reject flags alongside
	always_ff @(posedge clk) begin
		if (en) begin
			{tag_s3, tag_s4, tag_s5, tag_s6, tag_s7, tag_s8} <=
				{tag_s2, tag_s3, tag_s4, tag_s5, tag_s6, tag_s7};
			{face_s3, face_s4, face_s5, face_s6, face_s7, face_s8} <=
				{face_s2, face_s3, face_s4, face_s5, face_s6, face_s7};
			axis_s6 <= full_q && (|sep_s5);
			axis_s7 <= axis_s6;
			axis_s8 <= axis_s7;
		end
	end

	// result word
	assign m_axis_tvalid = v_s8;
	assign m_axis_tdata  = {7'b0, tag_s8, !(face_s8 || plane_s8 || axis_s8)};

	// checks
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s8 |-> s_axis_tready) else $error("input stalled with empty last stage");
	a_drain_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		en && v_s7 |=> m_axis_tvalid) else $error("word lost between stage 7 and 8");
	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(tag_s1) && $stable(v_s1)) else $error("stage 1 moved in stall");

endmodule

>>> tb/triangle_box_overlap_test_checker.sv
// ----------------------------------------------------------------------------
// triangle_box_overlap_test_checker
// Watches the configuration, triangle and result channels of the overlap
// block, keeps its own copy of the box registers, predicts the overlap flag
// of every accepted triangle word with exact wide arithmetic and compares
// each result word against the oldest prediction.
// ----------------------------------------------------------------------------
module triangle_box_overlap_test_checker import tbo_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	input  logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic [319:0] s_axis_tdata,
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [39:0]  m_axis_tdata,
	output int           failures,
	output int           pending
);

	typedef logic signed [191:0] wide_t;

	typedef struct packed {
		logic        overlaps;
		logic [31:0] tag;
	} overlap_result_t;

	// shadow of the box registers
	logic signed [31:0] centre [3];
	logic [30:0]        half_ext [3];
	logic               full_test;

	overlap_result_t expected_results [$];

	// one edge cross-axis: true if the axis separates triangle and box
	function automatic bit axis_splits(wide_t eia, wide_t eib, wide_t vpa, wide_t vpb,
			wide_t vqa, wide_t vqb, wide_t exa, wide_t exb);
		wide_t p0, p1, rad, lo, hi;
		p0 = eib * vpa - eia * vpb;
		p1 = eib * vqa - eia * vqb;
		rad = (eib < 0 ? -eib : eib) * exa + (eia < 0 ? -eia : eia) * exb;
		lo = (p0 > p1) ? p1 : p0;
		hi = (p0 > p1) ? p0 : p1;
		return (lo > rad) || (hi < -rad);
	endfunction

	function automatic logic predict_overlap(logic [319:0] d);
		wide_t v [3][3];
		wide_t ext [3];
		wide_t edg [3][3];
		wide_t nrm [3];
		wide_t lo, hi, cmin, cmax, dmin, dmax;
		logic signed [31:0] coord;
		for (int q = 0; q < 3; q++) begin
			ext[q] = {161'd0, half_ext[q]};
			for (int k = 0; k < 3; k++) begin
				coord = d[(k*3+q)*32 +: 32];
				v[k][q] = wide_t'(coord) - wide_t'(centre[q]);
			end
		end
		// box face axes
		for (int q = 0; q < 3; q++) begin
			lo = v[0][q];
			hi = v[0][q];
			for (int k = 1; k < 3; k++) begin
				if (v[k][q] < lo) lo = v[k][q];
				if (v[k][q] > hi) hi = v[k][q];
			end
			if (lo > ext[q] || hi < -ext[q])
				return 1'b0;
		end
		// triangle plane; a zero normal never rejects here
		for (int q = 0; q < 3; q++) begin
			edg[0][q] = v[1][q] - v[0][q];
			edg[1][q] = v[2][q] - v[1][q];
			edg[2][q] = v[0][q] - v[2][q];
		end
		nrm[0] = edg[0][1] * edg[1][2] - edg[0][2] * edg[1][1];
		nrm[1] = edg[0][2] * edg[1][0] - edg[0][0] * edg[1][2];
		nrm[2] = edg[0][0] * edg[1][1] - edg[0][1] * edg[1][0];
		dmin = 0;
		dmax = 0;
		for (int q = 0; q < 3; q++) begin
			cmin = (nrm[q] > 0) ? -ext[q] : ext[q];
			cmax = (nrm[q] > 0) ? ext[q] : -ext[q];
			dmin = dmin + nrm[q] * (cmin - v[0][q]);
			dmax = dmax + nrm[q] * (cmax - v[0][q]);
		end
		if (dmin > 0 || dmax < 0)
			return 1'b0;
		// edge cross-axes, one per triangle edge and box axis
		if (full_test) begin
			for (int i = 0; i < 9; i++) begin
				if (axis_splits(edg[AxEdge[i]][AxIa[i]], edg[AxEdge[i]][AxIb[i]],
						v[AxVp[i]][AxIa[i]], v[AxVp[i]][AxIb[i]],
						v[AxVq[i]][AxIa[i]], v[AxVq[i]][AxIb[i]],
						ext[AxIa[i]], ext[AxIb[i]]))
					return 1'b0;
			end
		end
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		overlap_result_t exp_res;
		if (!arst_n) begin
			for (int q = 0; q < 3; q++) begin
				centre[q] = '0;
				half_ext[q] = '0;
			end
			full_test = 1'b1;
			failures = 0;
			pending = 0;
		end else begin
			// register writes
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					REG_CTR_X: centre[0] = cfg_data;
					REG_CTR_Y: centre[1] = cfg_data;
					REG_CTR_Z: centre[2] = cfg_data;
					REG_EXT_X: half_ext[0] = cfg_data[30:0];
					REG_EXT_Y: half_ext[1] = cfg_data[30:0];
					REG_EXT_Z: half_ext[2] = cfg_data[30:0];
					REG_FULL:  full_test = cfg_data[0];
					default: ;
				endcase
			end
			// accepted triangle word
			if (s_axis_tvalid && s_axis_tready) begin
				exp_res.overlaps = predict_overlap(s_axis_tdata);
				exp_res.tag = s_axis_tdata[288 +: 32];
				expected_results.push_back(exp_res);
			end
			// accepted result word
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_results.size() == 0) begin
					$error("result word with no triangle outstanding: %h", m_axis_tdata);
					failures++;
				end else begin
					exp_res = expected_results.pop_front();
					if (m_axis_tdata[0] !== exp_res.overlaps) begin
						$error("overlaps: expected %0d, got %0d", exp_res.overlaps,
							m_axis_tdata[0]);
						failures++;
					end
					if (m_axis_tdata[32:1] !== exp_res.tag) begin
						$error("result_tag: expected %h, got %h", exp_res.tag,
							m_axis_tdata[32:1]);
						failures++;
					end
				end
			end
			pending = expected_results.size();
		end
	end

endmodule

>>> tb/triangle_box_overlap_test_tb.sv
// ----------------------------------------------------------------------------
// triangle_box_overlap_test_tb
// Drives box settings and triangle words into the overlap block with random
// gaps and output stalls, including one long output hold-off; the checker
// beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module triangle_box_overlap_test_tb import tbo_pkg::*;;

	logic         clk;
	logic         arst_n;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [2:0]   cfg_index;
	logic [31:0]  cfg_data;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	// vertex0_x/y/z, vertex1_x/y/z, vertex2_x/y/z, triangle_tag, zero pad
	logic [319:0] s_axis_tdata;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	// overlaps, result_tag, zero pad
	logic [39:0]  m_axis_tdata;

	int failures;
	int pending;
	bit gaps_on;
	bit hold_req;

	// current box, used to aim triangles at it
	logic signed [31:0] box_ctr [3];
	logic [30:0]        box_ext [3];

	triangle_box_overlap_test DUT (.*);

	triangle_box_overlap_test_checker checker_i (.*);

	// clock
	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// run limit
	initial begin
		#4_000_000;
		$display("Test completed with failures");
		$finish;
	end

	// result side: random stalls and one long hold-off
	initial begin
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_axis_tready <= 1'b0;
				repeat (80) @(posedge clk);
				hold_req = 1'b0;
			end else if (gaps_on && $urandom_range(0, 5) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_CTR_X: box_ctr[0] = val;
			REG_CTR_Y: box_ctr[1] = val;
			REG_CTR_Z: box_ctr[2] = val;
			REG_EXT_X: box_ext[0] = val[30:0];
			REG_EXT_Y: box_ext[1] = val[30:0];
			REG_EXT_Z: box_ext[2] = val[30:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_box(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
			logic [31:0] hx, logic [31:0] hy, logic [31:0] hz, logic full);
		// stop offering and let the pipeline drain first
		s_axis_tvalid <= 1'b0;
		wait (pending == 0);
		repeat (12) @(posedge clk);
		write_reg(REG_CTR_X, cx);
		write_reg(REG_CTR_Y, cy);
		write_reg(REG_CTR_Z, cz);
		write_reg(REG_EXT_X, hx);
		write_reg(REG_EXT_Y, hy);
		write_reg(REG_EXT_Z, hz);
		write_reg(REG_FULL, {31'd0, full});
	endtask

	// offer one triangle word; valid stays high unless a gap follows
	task automatic send_tri(logic [31:0] c [9], logic [31:0] tag);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {tag, c[8], c[7], c[6], c[5], c[4], c[3], c[2], c[1], c[0]};
		do @(posedge clk); while (!s_axis_tready);
		if (gaps_on && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
	endtask

	// coordinate near the box on axis q, occasionally anywhere or at an extreme
	function automatic logic [31:0] rand_coord(int q);
		longint r;
		int sel;
		sel = $urandom_range(0, 9);
		if (sel == 0)
			return $urandom;
		if (sel == 1)
			return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
		r = longint'(box_ctr[q]) + (longint'($signed($urandom)) >>> $urandom_range(0, 31));
		if (sel < 5)
			r = longint'(box_ctr[q]) + ($urandom_range(0, 1) ? longint'(box_ext[q]) :
				-longint'(box_ext[q])) + (longint'($signed($urandom)) >>> 28);
		if (r > 64'sh7FFF_FFFF) r = 64'sh7FFF_FFFF;
		if (r < -64'sh8000_0000) r = -64'sh8000_0000;
		return r[31:0];
	endfunction

	task automatic send_random(int count);
		logic [31:0] c [9];
		repeat (count) begin
			for (int i = 0; i < 9; i++)
				c[i] = rand_coord(i % 3);
			// sometimes a degenerate triangle: repeat a vertex
			if ($urandom_range(0, 9) == 0)
				for (int q = 0; q < 3; q++)
					c[3 + q] = c[q];
			send_tri(c, $urandom);
		end
	endtask

	task automatic send_same(logic [31:0] a, logic [31:0] b, logic [31:0] tag);
		logic [31:0] c [9];
		for (int i = 0; i < 9; i++)
			c[i] = (i < 3) ? a : b;
		send_tri(c, tag);
	endtask

	// stimulus
	initial begin
		logic [31:0] c [9];
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_CTR_X;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		gaps_on = 1'b1;
		hold_req = 1'b0;
		for (int q = 0; q < 3; q++) begin
			box_ctr[q] = '0;
			box_ext[q] = '0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: point box at the origin after reset
		send_same(32'd0, 32'd0, 32'd0);
		send_same(32'd0, 32'h0001_0000, 32'hFFFF_FFFF);
		send_same(32'h7FFF_FFFF, 32'h8000_0000, 32'hA5A5_A5A5);
		send_same(32'h8000_0000, 32'h8000_0000, 32'h5A5A_5A5A);

		// directed: unit box, touching, far, degenerate, extremes
		set_box(0, 0, 0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1'b1);
		c = '{32'h0001_0000, 0, 0, 32'h0002_0000, 32'h0001_0000, 0,
			32'h0002_0000, 0, 32'h0001_0000};
		send_tri(c, 1);
		c = '{32'h0001_0001, 0, 0, 32'h0002_0000, 32'h0001_0000, 0,
			32'h0002_0000, 0, 32'h0001_0000};
		send_tri(c, 2);
		// plane passes near a corner, rejected only by an edge axis or the plane
		c = '{32'h0003_0000, 0, 0, 0, 32'h0003_0000, 0, 0, 0, 32'h0003_0000};
		send_tri(c, 3);
		c = '{32'h0001_8000, 32'h0001_8000, 32'hFFFF_0000, 32'hFFFE_0000,
			32'h0001_8000, 32'hFFFF_0000, 32'h0001_8000, 32'hFFFE_0000, 32'h0001_0000};
		send_tri(c, 4);
		c = '{32'hFFFF_0000, 32'hFFFF_0000, 0, 32'h0001_0000, 32'h0001_0000, 0,
			32'h0002_0000, 32'h0002_0000, 0};
		send_tri(c, 5);
		c = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 32'h7FFF_FFFF};
		send_tri(c, 6);
		send_same(32'h8000_0000, 32'h7FFF_FFFF, 7);
		set_box(0, 0, 0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1'b0);
		c = '{32'h0003_0000, 0, 0, 0, 32'h0003_0000, 0, 0, 0, 32'h0003_0000};
		send_tri(c, 8);
		c = '{32'h0001_8000, 32'h0001_8000, 32'hFFFF_0000, 32'hFFFE_0000,
			32'h0001_8000, 32'hFFFF_0000, 32'h0001_8000, 32'hFFFE_0000, 32'h0001_0000};
		send_tri(c, 9);

		// random phases across box settings, extremes among them
		set_box(32'h0010_0000, 32'hFFF0_0000, 32'h0000_8000,
			32'h0004_0000, 32'h0002_0000, 32'h0008_0000, 1'b1);
		send_random(60);
		hold_req = 1'b1;
		send_random(30);
		set_box(32'h0010_0000, 32'hFFF0_0000, 32'h0000_8000,
			32'h0004_0000, 32'h0002_0000, 32'h0008_0000, 1'b0);
		send_random(60);
		set_box(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
		send_random(50);
		set_box(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 1'b1);
		send_random(40);
		set_box($urandom, $urandom, $urandom, $urandom_range(0, 32'h00FF_FFFF),
			$urandom_range(0, 32'h00FF_FFFF), $urandom_range(0, 32'h00FF_FFFF), 1'b1);
		send_random(60);
		set_box(0, 0, 0, 32'h0100_0000, 0, 32'h0100_0000, 1'b1);
		send_random(50);
		set_box($urandom, $urandom, $urandom, $urandom_range(0, 32'h0FFF_FFFF),
			$urandom_range(0, 32'h0FFF_FFFF), $urandom_range(0, 32'h0FFF_FFFF), 1'b1);
		gaps_on = 1'b0;
		send_random(70);
		s_axis_tvalid <= 1'b0;

		// drain and verdict
		wait (pending == 0);
		repeat (20) @(posedge clk);
		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
